>>> rtl/bfbp_pkg.sv
// Shared constants, types and codes of the best-fit bin packer.
package bfbp_pkg;

  localparam int MAX_BINS = 64;
  localparam int VAL_W    = 31;
  localparam int CNT_W    = $clog2(MAX_BINS + 1);
  localparam int STAT_W   = 2;
  localparam int OPEN_W   = 7;
  localparam int IN_W     = 32;
  localparam int OUT_W    = STAT_W + VAL_W + OPEN_W;
  localparam logic [VAL_W-1:0] CAP_RESET = VAL_W'(1000000);

  typedef enum logic [STAT_W-1:0] {
    STAT_PLACED   = 2'd0,
    STAT_NEW      = 2'd1,
    STAT_OVERSIZE = 2'd2,
    STAT_FULL     = 2'd3
  } bfbp_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_CALC,
    S_INS
  } bfbp_state_t;

  // Commands broadcast to every cell of the row.
  typedef struct packed {
    logic             find;
    logic             ins;
    logic [VAL_W-1:0] size;
    logic [VAL_W-1:0] newval;
  } bfbp_ctl_t;

  // What one cell hands to its right-hand neighbor.
  typedef struct packed {
    logic             hit;
    logic             ins_hit;
    logic [VAL_W-1:0] val;
  } bfbp_link_t;

  // Reduced view of the target cell found by the search.
  typedef struct packed {
    logic             any;
    logic             is_open;
    logic [VAL_W-1:0] val;
  } bfbp_sel_t;

endpackage

>>> rtl/bfbp_cell.sv
// One bin cell of the sorted row: holds a remaining capacity and shifts on insert.
module bfbp_cell (
  input  logic                         clk,
  input  bfbp_pkg::bfbp_ctl_t          ctl,
  input  logic                         valid,
  input  bfbp_pkg::bfbp_link_t         prev,
  output bfbp_pkg::bfbp_link_t         link,
  output logic                         at_k,
  output logic                         sel_open,
  output logic [bfbp_pkg::VAL_W-1:0]   sel_val
);

  logic [bfbp_pkg::VAL_W-1:0] val_r;
  logic                       at_k_r;
  logic                       beyond_r;
  logic                       hit;
  logic                       ins_hit;

  // Empty cells sit at the tail of the row and always count as a hit.
  assign hit     = !valid || (val_r >= ctl.size);
  assign ins_hit = !valid || (val_r >= ctl.newval);

  assign link.hit     = hit;
  assign link.ins_hit = ins_hit;
  assign link.val     = val_r;

  assign at_k     = at_k_r;
  assign sel_open = at_k_r && valid;
  assign sel_val  = at_k_r ? val_r : '0;

  always_ff @(posedge clk) begin
    if (ctl.find) begin
      at_k_r   <= hit && !prev.hit;
      beyond_r <= prev.hit;
    end
    // Insert point takes newval; later cells up to the target take the left value.
    if (ctl.ins && ins_hit && !beyond_r) begin
      val_r <= prev.ins_hit ? prev.val : ctl.newval;
    end
  end

endmodule

>>> rtl/bfbp_chain.sv
// Row of bin cells with the reduction that picks out the target cell.
module bfbp_chain (
  input  logic                        clk,
  input  bfbp_pkg::bfbp_ctl_t         ctl,
  input  logic [bfbp_pkg::CNT_W-1:0]  count,
  output bfbp_pkg::bfbp_sel_t         sel
);

  bfbp_pkg::bfbp_link_t                 links [bfbp_pkg::MAX_BINS+1];
  logic [bfbp_pkg::MAX_BINS-1:0]        at_k;
  logic [bfbp_pkg::MAX_BINS-1:0]        sel_open;
  logic [bfbp_pkg::VAL_W-1:0]           sel_val [bfbp_pkg::MAX_BINS];

  assign links[0] = '0;

  for (genvar i = 0; i < bfbp_pkg::MAX_BINS; i++) begin : g_cell
    bfbp_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .valid    (count > bfbp_pkg::CNT_W'(i)),
      .prev     (links[i]),
      .link     (links[i+1]),
      .at_k     (at_k[i]),
      .sel_open (sel_open[i]),
      .sel_val  (sel_val[i])
    );
  end

  // At most one cell marks itself as target, so an OR picks its value.
  always_comb begin
    sel.any     = |at_k;
    sel.is_open = |sel_open;
    sel.val     = '0;
    for (int i = 0; i < bfbp_pkg::MAX_BINS; i++) begin
      sel.val = sel.val | sel_val[i];
    end
  end

endmodule

>>> rtl/best_fit_bin_packer.sv
// Top level of the best-fit bin packer: handshakes, sequencer and the bin row.
// A placed item or a newly opened bin passes through these steps from acceptance
// to the next free input slot: accept, a parallel compare of every bin cell
// against the size, selection of the best bin with one subtract, and a shift of
// the sorted row that drops the updated value into place. An oversized item or
// one that meets a full table skips the shift. The
// bins are kept in ascending order, so the best fit is the first cell whose
// capacity is not below the size. A result sits in an output register and the
// next item is taken while it waits; a new result is held back only while the
// previous one is unread.
module best_fit_bin_packer (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: item_size [30:0], zero [31]
  input  logic [bfbp_pkg::IN_W-1:0]      in_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // out_tdata: status [1:0], remaining_after [32:2], open_bins [39:33]
  output logic [bfbp_pkg::OUT_W-1:0]     out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_wr_en,
  input  logic [bfbp_pkg::VAL_W-1:0]     cfg_wr_data
);

  bfbp_pkg::bfbp_state_t            state_r, state_nxt;
  logic [bfbp_pkg::VAL_W-1:0]       cap_r;
  logic [bfbp_pkg::VAL_W-1:0]       size_r;
  logic [bfbp_pkg::VAL_W-1:0]       newval_r;
  logic [bfbp_pkg::CNT_W-1:0]       count_r;
  logic                             over_r;
  logic                             new_r;
  logic                             out_valid_r;
  logic [bfbp_pkg::OUT_W-1:0]       out_data_r;

  bfbp_pkg::bfbp_ctl_t              ctl;
  bfbp_pkg::bfbp_sel_t              sel;
  bfbp_pkg::bfbp_status_t           status;
  logic [bfbp_pkg::VAL_W-1:0]       rem;
  logic [bfbp_pkg::CNT_W-1:0]       count_after;
  logic                             in_acc;
  logic                             slot_free;
  logic                             load_out;
  logic                             do_find;
  logic                             do_ins;

  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  bfbp_chain u_chain (
    .clk   (clk),
    .ctl   (ctl),
    .count (count_r),
    .sel   (sel)
  );

  // Result of the search, valid in the selection cycle.
  always_comb begin
    if (over_r) begin
      status = bfbp_pkg::STAT_OVERSIZE;
      rem    = '0;
    end else if (!sel.any) begin
      status = bfbp_pkg::STAT_FULL;
      rem    = '0;
    end else if (sel.is_open) begin
      status = bfbp_pkg::STAT_PLACED;
      rem    = sel.val - size_r;
    end else begin
      status = bfbp_pkg::STAT_NEW;
      rem    = cap_r - size_r;
    end
    count_after = (status == bfbp_pkg::STAT_NEW) ? count_r + 1'b1 : count_r;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfbp_pkg::S_IDLE: if (in_tvalid) state_nxt = bfbp_pkg::S_FIND;
      bfbp_pkg::S_FIND: state_nxt = bfbp_pkg::S_CALC;
      bfbp_pkg::S_CALC: begin
        if (slot_free) begin
          if (status == bfbp_pkg::STAT_PLACED || status == bfbp_pkg::STAT_NEW) begin
            state_nxt = bfbp_pkg::S_INS;
          end else begin
            state_nxt = bfbp_pkg::S_IDLE;
          end
        end
      end
      bfbp_pkg::S_INS:  state_nxt = bfbp_pkg::S_IDLE;
      default:          state_nxt = bfbp_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_tready = 1'b0;
    do_find   = 1'b0;
    do_ins    = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      bfbp_pkg::S_IDLE: in_tready = 1'b1;
      bfbp_pkg::S_FIND: do_find   = 1'b1;
      bfbp_pkg::S_CALC: load_out  = slot_free;
      bfbp_pkg::S_INS:  do_ins    = 1'b1;
      default:          in_tready = 1'b0;
    endcase
  end

  assign ctl.find   = do_find;
  assign ctl.ins    = do_ins;
  assign ctl.size   = size_r;
  assign ctl.newval = newval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfbp_pkg::S_IDLE;
      cap_r       <= bfbp_pkg::CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      if (do_ins && new_r) count_r <= count_r + 1'b1;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) size_r <= in_tdata[bfbp_pkg::VAL_W-1:0];
    if (do_find) over_r <= size_r > cap_r;
    if (load_out) begin
      newval_r   <= rem;
      new_r      <= (status == bfbp_pkg::STAT_NEW);
      out_data_r <= {bfbp_pkg::OPEN_W'(count_after), rem, status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> rtl/bfbp_checker.sv
// Port-level checks of the best-fit bin packer, bound to the top level.
module bfbp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [bfbp_pkg::OUT_W-1:0]  out_tdata,
  input logic                        out_tvalid,
  input logic                        out_tready
);

  localparam int RemLo  = bfbp_pkg::STAT_W;
  localparam int RemHi  = bfbp_pkg::STAT_W + bfbp_pkg::VAL_W - 1;
  localparam int OpenLo = RemHi + 1;

  logic [bfbp_pkg::STAT_W-1:0] st;
  logic [bfbp_pkg::VAL_W-1:0]  rem;
  logic [bfbp_pkg::OPEN_W-1:0] open;

  assign st   = out_tdata[bfbp_pkg::STAT_W-1:0];
  assign rem  = out_tdata[RemHi:RemLo];
  assign open = out_tdata[bfbp_pkg::OUT_W-1:OpenLo];

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Work on one item at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while busy");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st == bfbp_pkg::STAT_OVERSIZE || st == bfbp_pkg::STAT_FULL) |-> rem == '0)
    else $error("rejected item shows a remainder");

  a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> open <= bfbp_pkg::OPEN_W'(bfbp_pkg::MAX_BINS)
                   && (st == bfbp_pkg::STAT_OVERSIZE || open != '0
                       || st == bfbp_pkg::STAT_FULL))
    else $error("open bin count out of range");

endmodule

bind best_fit_bin_packer bfbp_checker u_bfbp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
